@@ src/divtmr_pkg.sv @@
// Shared types, constants and a helper function for the divider and timer block.
`timescale 1ns / 1ps

package divtmr_pkg;

    // Kind of request carried on the input channel.
    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    // Timer register selected by a bus access.
    typedef enum logic [1:0] {
        REG_DIV     = 2'd0,
        REG_COUNTER = 2'd1,
        REG_TMA     = 2'd2,
        REG_TAC     = 2'd3
    } reg_sel_t;

    // Configuration register indexes on the APB port.
    typedef enum logic {
        CFG_HALF_STEP = 1'b0,
        CFG_APU_BIT   = 1'b1
    } cfg_index_t;

    // Configuration handed from the register file to the timer core.
    typedef struct packed {
        logic       half_step;
        logic [3:0] apu_bit;
    } cfg_t;

    localparam logic [15:0] DIV_RESET      = 16'hABCC;
    localparam logic [7:0]  TAC_RESET      = 8'hF8;
    localparam logic [7:0]  TIMA_MAX       = 8'hFF;
    localparam logic [2:0]  TICK_CLOCKS    = 3'd4;
    localparam logic [2:0]  RELOAD_CLOCKS  = 3'd4;
    localparam logic [3:0]  APU_BIT_RESET  = 4'd12;
    localparam int          TAC_ENABLE_BIT = 2;

    // Divider bit watched by TIMA for each TAC rate selection.
    function automatic logic [3:0] rate_bit(input logic [1:0] rate_sel);
        logic [3:0] bit_idx;
        unique case (rate_sel)
            2'd0:    bit_idx = 4'd9;
            2'd1:    bit_idx = 4'd3;
            2'd2:    bit_idx = 4'd5;
            default: bit_idx = 4'd7;
        endcase
        return bit_idx;
    endfunction

endpackage

@@ src/divtmr_cfg.sv @@
// APB configuration registers: double speed flag and audio divider bit select.
`timescale 1ns / 1ps

module divtmr_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output divtmr_pkg::cfg_t    cfg
);
    import divtmr_pkg::*;

    logic       half_step_reg;
    logic [3:0] apu_bit_reg;
    logic       wr_en;
    cfg_index_t wr_index;

    // Registers sit four bytes apart, so bit 2 of the address picks one.
    assign wr_index = cfg_index_t'(paddr[2]);
    assign wr_en    = psel & penable & pwrite;
    assign pready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            half_step_reg <= 1'b0;
            apu_bit_reg   <= APU_BIT_RESET;
        end else if (wr_en) begin
            unique case (wr_index)
                CFG_HALF_STEP: half_step_reg <= pwdata[0];
                default:       apu_bit_reg   <= pwdata[3:0];
            endcase
        end
    end

    always_comb begin
        unique case (wr_index)
            CFG_HALF_STEP: prdata = {31'd0, half_step_reg};
            default:       prdata = {28'd0, apu_bit_reg};
        endcase
    end

    assign cfg.half_step = half_step_reg;
    assign cfg.apu_bit   = apu_bit_reg;

endmodule

@@ src/divtmr_core.sv @@
// Timer state (divider, TIMA, TMA, TAC, reload delay) and its one-pass update.
`timescale 1ns / 1ps

module divtmr_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  divtmr_pkg::cfg_t        cfg,
    input  logic                    fire,
    input  divtmr_pkg::mode_t       mode,
    input  divtmr_pkg::reg_sel_t    reg_select,
    input  logic [7:0]              write_data,
    output logic [7:0]              read_data,
    output logic                    timer_irq,
    output logic                    apu_step
);
    import divtmr_pkg::*;

    logic [15:0] div_reg,   div_next;
    logic [7:0]  tima_reg,  tima_next;
    logic [7:0]  tma_reg,   tma_next;
    logic [7:0]  tac_reg,   tac_next;
    logic [2:0]  delay_reg, delay_next;

    logic [2:0]  step;
    logic [15:0] div_adv;
    logic [2:0]  delay_dec;
    logic        sig_before;
    logic        sig_after;
    logic        bump;
    logic        tac_enable;

    assign tac_enable = tac_reg[TAC_ENABLE_BIT];
    assign step       = cfg.half_step ? (TICK_CLOCKS >> 1) : TICK_CLOCKS;
    assign div_adv    = div_reg + {13'd0, step};
    assign delay_dec  = (delay_reg >= step) ? (delay_reg - step) : 3'd0;
    assign sig_before = tac_enable & div_reg[rate_bit(tac_reg[1:0])];
    assign sig_after  = tac_enable & div_adv[rate_bit(tac_reg[1:0])];

    always_comb begin
        div_next   = div_reg;
        tima_next  = tima_reg;
        tma_next   = tma_reg;
        tac_next   = tac_reg;
        delay_next = delay_reg;
        read_data  = 8'd0;
        timer_irq  = 1'b0;
        apu_step   = 1'b0;
        bump       = 1'b0;

        case (mode)
            MODE_TICK: begin
                div_next = div_adv;
                if (delay_reg != 3'd0) begin
                    delay_next = delay_dec;
                    timer_irq  = (delay_dec == 3'd0);
                end
                bump = sig_before & ~sig_after;
            end
            MODE_READ: begin
                case (reg_select)
                    REG_DIV:     read_data = div_reg[15:8];
                    REG_COUNTER: read_data = (delay_reg != 3'd0) ? 8'd0 : tima_reg;
                    REG_TMA:     read_data = tma_reg;
                    default:     read_data = tac_reg;
                endcase
            end
            MODE_WRITE: begin
                case (reg_select)
                    REG_DIV: begin
                        // Clearing the divider drops the timer signal if it was high.
                        bump     = sig_before;
                        apu_step = div_reg[cfg.apu_bit];
                        div_next = 16'd0;
                    end
                    REG_COUNTER: begin
                        if (delay_reg == 3'd0)
                            tima_next = write_data;
                    end
                    REG_TMA: begin
                        if (delay_reg == 3'd0)
                            tma_next = write_data;
                    end
                    default: begin
                        // Disabling the timer checks the newly selected bit.
                        bump = tac_enable & ~write_data[TAC_ENABLE_BIT]
                               & div_reg[rate_bit(write_data[1:0])];
                        tac_next = write_data;
                    end
                endcase
            end
            default: ;
        endcase

        if (bump) begin
            if (tima_reg == TIMA_MAX) begin
                tima_next  = tma_reg;
                delay_next = RELOAD_CLOCKS;
            end else begin
                tima_next = tima_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            div_reg   <= DIV_RESET;
            tima_reg  <= 8'd0;
            tma_reg   <= 8'd0;
            tac_reg   <= TAC_RESET;
            delay_reg <= 3'd0;
        end else if (fire) begin
            div_reg   <= div_next;
            tima_reg  <= tima_next;
            tma_reg   <= tma_next;
            tac_reg   <= tac_next;
            delay_reg <= delay_next;
        end
    end

endmodule

@@ src/divider_timer_with_reload_delay_top.sv @@
// Top level of the divider and timer block: request and result registers around the core.
`timescale 1ns / 1ps
// A request accepted into the input register is processed by the core and registered in
// the output register. Throughput: one request per clock while out_stall is low; a stalled
// result holds one request back in the input register while the output register waits.
// Reset (rst_n, asynchronous, active low) empties both pipeline stages and loads the
// timer and configuration registers with their power-on values; no clearing pass follows.

module divider_timer_with_reload_delay_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [1:0]  reg_select,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic        timer_irq,
    output logic        apu_step
);
    import divtmr_pkg::*;

    cfg_t     cfg;

    // Input register: holds one request until the core can process it.
    logic     s1_valid_reg;
    mode_t    s1_mode_reg;
    reg_sel_t s1_sel_reg;
    logic [7:0] s1_data_reg;

    // Output register: holds the result until the receiver takes it.
    logic       out_valid_reg;
    logic [7:0] read_data_reg;
    logic       timer_irq_reg;
    logic       apu_step_reg;

    logic       advance;
    logic       fire;
    logic       in_accept;
    logic [7:0] core_read_data;
    logic       core_timer_irq;
    logic       core_apu_step;

    divtmr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The output register can load whenever it is empty or being drained this cycle,
    // so the core processes the held request and the input register refills together.
    assign advance   = ~out_valid_reg | ~out_stall;
    assign fire      = s1_valid_reg & advance;
    assign in_stall  = s1_valid_reg & ~advance;
    assign in_accept = in_valid & ~in_stall;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (advance | ~s1_valid_reg) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_accept) begin
            s1_mode_reg <= mode_t'(mode);
            s1_sel_reg  <= reg_sel_t'(reg_select);
            s1_data_reg <= write_data;
        end
    end

    divtmr_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .fire       (fire),
        .mode       (s1_mode_reg),
        .reg_select (s1_sel_reg),
        .write_data (s1_data_reg),
        .read_data  (core_read_data),
        .timer_irq  (core_timer_irq),
        .apu_step   (core_apu_step)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (fire) begin
            read_data_reg <= core_read_data;
            timer_irq_reg <= core_timer_irq;
            apu_step_reg  <= core_apu_step;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign timer_irq = timer_irq_reg;
    assign apu_step  = apu_step_reg;

`ifndef SYNTHESIS
    // A request held in the input register is never dropped while the output is blocked.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> s1_valid_reg)
        else $error("held request lost from input register");

    // Every request processed by the core appears as a result in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed request produced no result");

    // An audio step can only come from a bus write.
    a_apu_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s1_mode_reg != MODE_WRITE) |=> !apu_step_reg)
        else $error("audio step without a DIV write");

    // The timer interrupt can only come from a tick.
    a_irq_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s1_mode_reg != MODE_TICK) |=> !timer_irq_reg)
        else $error("timer interrupt without a tick");
`endif

endmodule
